[rtl/vsd_pkg.sv]
`timescale 1ns / 1ps
// Package for the varint stream decoder: beat types, kind codes and byte limits.
// Used by every module of the block; depends on nothing else.
package vsd_pkg;

   // Value kind codes as carried in req_type. The last code is decoded as a long.
   localparam logic [1:0] KIND_INT   = 2'd0;
   localparam logic [1:0] KIND_SHORT = 2'd1;
   localparam logic [1:0] KIND_LONG  = 2'd2;
   localparam logic [1:0] KIND_RSVD  = 2'd3;

   // Maximum number of encoded bytes per kind.
   localparam logic [3:0] LIMIT_INT   = 4'd5;
   localparam logic [3:0] LIMIT_SHORT = 4'd3;
   localparam logic [3:0] LIMIT_LONG  = 4'd10;

   localparam int unsigned CHUNK_BITS = 7;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
   } req_beat_type;

   typedef struct packed {
      logic [63:0] value;
      logic        error;
      logic [3:0]  bytes_used;
   } rsp_beat_type;

   // Handshake between the decode core and the result register.
   typedef struct packed {
      logic advance;   // the held byte is consumed this cycle
      logic load;      // a result is written into the result register
   } step_ctl_type;

   function automatic logic [1:0] kind_of(input logic [1:0] code);
      logic [1:0] kind;
      unique case (code)
         KIND_INT:   kind = KIND_INT;
         KIND_SHORT: kind = KIND_SHORT;
         KIND_LONG:  kind = KIND_LONG;
         KIND_RSVD:  kind = KIND_LONG;
         default:    kind = KIND_LONG;
      endcase
      return kind;
   endfunction

   function automatic logic [3:0] limit_of(input logic [1:0] kind);
      logic [3:0] limit;
      unique case (kind)
         KIND_INT:   limit = LIMIT_INT;
         KIND_SHORT: limit = LIMIT_SHORT;
         default:    limit = LIMIT_LONG;
      endcase
      return limit;
   endfunction

   // Fold the gathered bits to the kind's width and sign-extend.
   function automatic logic [63:0] finish_value(input logic [1:0] kind, input logic [63:0] acc);
      logic [63:0] v;
      unique case (kind)
         KIND_INT:   v = {{32{acc[31]}}, acc[31:0]};
         KIND_SHORT: v = {{48{acc[15]}}, acc[15:0]};
         default:    v = acc;
      endcase
      return v;
   endfunction

endpackage

[rtl/varint_stream_decoder.sv]
`timescale 1ns / 1ps
// Varint stream decoder, top level: unsigned little-endian 7-bit-chunk varint decoding.
// Depends on vsd_pkg, vsd_in_reg, vsd_core and vsd_out_reg.
//
// The block takes one encoded byte per req beat and returns one rsp beat on the byte that
// ends a value. Bits 6..0 of each byte are payload, lowest chunk first, and bit 7 set means
// more bytes follow. The kind of a value is taken from req_type on its first byte only:
// int gives the low 32 bits sign-extended to 64, short the low 16 bits sign-extended, and
// long (also the unused code 3) the exact unsigned 64-bit number, where only bit 0 of a
// tenth byte's payload is kept. A value that still has bit 7 set on its fifth (int), third
// (short) or tenth (long) byte is closed with error set, value zero and bytes_used equal to
// that limit; the next byte starts a new value. The block accepts one byte in every cycle
// as long as results are drained; a byte that ends a value passes through the input
// register and then the result register before it leaves as a result.
// Bytes that do not end a value never wait for the rsp side. Throughput is bounded only by
// the single decode step between those two registers, which shifts seven bits into the
// accumulator per byte.
module varint_stream_decoder
   import vsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data
);

   logic         hold_valid;
   req_beat_type hold_data;
   logic         out_free;
   step_ctl_type step_ctl;
   rsp_beat_type result;

   // Input register: parts the req handshake from the decode step.
   vsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (step_ctl.advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   // Decode step: folds the held byte into the value state and forms the result.
   vsd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid),
      .hold_data  (hold_data),
      .out_free   (out_free),
      .step_ctl   (step_ctl),
      .result     (result)
   );

   // Result register: holds a finished beat while the rsp side stalls.
   vsd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .step_ctl  (step_ctl),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/vsd_in_reg.sv]
`timescale 1ns / 1ps
// Input register of the varint stream decoder: holds one accepted request beat.
// Depends on vsd_pkg.
module vsd_in_reg
   import vsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_data,
   input  logic         advance,
   output logic         hold_valid,
   output req_beat_type hold_data
);

   logic         valid_ff;
   logic         valid_in;
   req_beat_type data_ff;

   // The register takes a new beat when empty or when its beat leaves this cycle.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

[rtl/vsd_core.sv]
`timescale 1ns / 1ps
// Decode core of the varint stream decoder: value state and per-byte decode logic.
// Depends on vsd_pkg.
module vsd_core
   import vsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         hold_valid,
   input  req_beat_type hold_data,
   input  logic         out_free,
   output step_ctl_type step_ctl,
   output rsp_beat_type result
);

   logic [63:0] acc_ff;
   logic [63:0] acc_in;
   logic [3:0]  idx_ff;
   logic [3:0]  idx_in;
   logic [1:0]  kind_ff;
   logic [1:0]  kind_in;

   logic        first;
   logic [6:0]  shift_amt;
   logic [63:0] chunk;
   logic [3:0]  count;
   logic [3:0]  limit;
   logic        last_byte;
   logic        overlong;
   logic        emit;

   always_comb begin
      first     = (idx_ff == 4'd0);
      kind_in   = first ? kind_of(hold_data.req_type) : kind_ff;
      // idx * 7 as idx * 8 - idx; at most 63 since a value never passes ten bytes.
      shift_amt = {idx_ff, 3'b000} - {3'b000, idx_ff};
      chunk     = {57'd0, hold_data.data_byte[6:0]} << shift_amt;
      acc_in    = (first ? 64'd0 : acc_ff) | chunk;
      count     = idx_ff + 4'd1;
      limit     = limit_of(kind_in);
      last_byte = !hold_data.data_byte[7];
      overlong  = hold_data.data_byte[7] && (count >= limit);
      emit      = last_byte || overlong;
      idx_in    = emit ? 4'd0 : count;

      step_ctl.advance = hold_valid && (!emit || out_free);
      step_ctl.load    = hold_valid && emit && out_free;

      result.value      = overlong ? 64'd0 : finish_value(kind_in, acc_in);
      result.error      = overlong;
      result.bytes_used = overlong ? limit : count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= 4'd0;
         kind_ff <= KIND_INT;
      end else if (step_ctl.advance) begin
         idx_ff  <= idx_in;
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_ctl.advance) begin
         acc_ff <= acc_in;
      end
   end

`ifndef SYNTHESIS
   // A value never runs past the long limit.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < LIMIT_LONG)
      else $error("byte index beyond long limit");

   // Short and int values end before their own limits.
   a_short_limit: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 4'd0 && kind_ff == KIND_SHORT) |-> idx_ff < LIMIT_SHORT)
      else $error("short value past its byte limit");

   a_int_limit: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 4'd0 && kind_ff == KIND_INT) |-> idx_ff < LIMIT_INT)
      else $error("int value past its byte limit");

   // Every emitted result closes its value.
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      step_ctl.load |=> idx_ff == 4'd0)
      else $error("decoder not idle after a result");
`endif

endmodule

[rtl/vsd_out_reg.sv]
`timescale 1ns / 1ps
// Result register of the varint stream decoder: holds one result beat for the rsp channel.
// Depends on vsd_pkg.
module vsd_out_reg
   import vsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  step_ctl_type step_ctl,
   input  rsp_beat_type result,
   output logic         out_free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data
);

   logic         valid_ff;
   logic         valid_in;
   rsp_beat_type data_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = step_ctl.load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_ctl.load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[test/varint_decode_checker.sv]
`timescale 1ns / 1ps
// Checker for the varint stream decoder: it follows the accepted req beats, predicts each result
// and compares it with the accepted rsp beats. Depends on vsd_pkg only.
module varint_decode_checker
   import vsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_beat_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_beat_type rsp_data,
   output int           mismatches,
   output int           outstanding,
   output int           values_checked,
   output int           overlong_checked
);

   rsp_beat_type decoded_q[$];
   logic [63:0]  gathered_bits;
   logic [3:0]   bytes_taken;
   logic [1:0]   value_kind;

   function automatic logic [3:0] byte_budget(input logic [1:0] kind);
      case (kind)
         KIND_INT:   return LIMIT_INT;
         KIND_SHORT: return LIMIT_SHORT;
         default:    return LIMIT_LONG;
      endcase
   endfunction

   // Int and short keep their low word or half word, read as a signed number.
   function automatic logic [63:0] fold_to_kind(input logic [1:0] kind, input logic [63:0] bits);
      logic signed [31:0] word;
      logic signed [15:0] half;
      logic signed [63:0] wide;
      word = bits[31:0];
      half = bits[15:0];
      case (kind)
         KIND_INT:   wide = word;
         KIND_SHORT: wide = half;
         default:    wide = bits;
      endcase
      return wide;
   endfunction

   always @(posedge clock) begin : watch
      logic [1:0]   kind;
      logic [63:0]  bits;
      logic [3:0]   count;
      rsp_beat_type want;
      rsp_beat_type got;
      if (reset) begin
         decoded_q.delete();
         gathered_bits = '0;
         bytes_taken = '0;
         value_kind = KIND_INT;
         mismatches = 0;
         outstanding = 0;
         values_checked = 0;
         overlong_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (decoded_q.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %h err %b bytes %0d",
                        $time, got.value, got.error, got.bytes_used);
               mismatches++;
            end else begin
               want = decoded_q.pop_front();
               if (got.value !== want.value) begin
                  $display("%0t ns: value mismatch, expected %h, actual %h",
                           $time, want.value, got.value);
                  mismatches++;
               end
               if (got.error !== want.error) begin
                  $display("%0t ns: error flag mismatch, expected %b, actual %b",
                           $time, want.error, got.error);
                  mismatches++;
               end
               if (got.bytes_used !== want.bytes_used) begin
                  $display("%0t ns: bytes_used mismatch, expected %0d, actual %0d",
                           $time, want.bytes_used, got.bytes_used);
                  mismatches++;
               end
               if (want.error) overlong_checked++;
               else values_checked++;
            end
         end

         if (req_valid && req_ready) begin
            // The kind is latched from the first byte of a value only.
            if (bytes_taken == 0) begin
               kind = (req_data.req_type == KIND_RSVD) ? KIND_LONG : req_data.req_type;
               bits = '0;
            end else begin
               kind = value_kind;
               bits = gathered_bits;
            end
            bits |= {57'd0, req_data.data_byte[6:0]} << (bytes_taken * CHUNK_BITS);
            count = bytes_taken + 4'd1;
            if (!req_data.data_byte[7]) begin
               decoded_q.push_back('{value: fold_to_kind(kind, bits), error: 1'b0,
                                     bytes_used: count});
               bytes_taken = '0;
            end else if (count >= byte_budget(kind)) begin
               decoded_q.push_back('{value: '0, error: 1'b1, bytes_used: byte_budget(kind)});
               bytes_taken = '0;
            end else begin
               bytes_taken = count;
            end
            gathered_bits = bits;
            value_kind = kind;
         end
         outstanding = decoded_q.size();
      end
   end

endmodule

[test/varint_stream_decoder_test.sv]
`timescale 1ns / 1ps
// Testbench top for the varint stream decoder: clock, reset, req stimulus, rsp back-pressure
// and the verdict. Depends on vsd_pkg, varint_stream_decoder and varint_decode_checker.
module varint_stream_decoder_test;
   import vsd_pkg::*;

   localparam int RANDOM_BEATS = 1350;
   // The random part rotates through the idle mixes every this many beats.
   localparam int PHASE_BEATS  = 150;
   localparam int CYCLE_LIMIT  = 200_000;
   // Cycles allowed after the last result, for any extra result of the block to show.
   localparam int DRAIN_CYCLES = 16;

   // Every input of the block starts at a known value; reset is held from time zero.
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_data;

   int mismatches;
   int outstanding;
   int values_checked;
   int overlong_checked;
   int cycle_count = 0;
   int beats_sent = 0;
   // Percent of cycles in which the sender holds back a beat and the receiver stalls.
   int send_idle_pct = 0;
   int take_stall_pct = 0;

   varint_stream_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   varint_decode_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .values_checked   (values_checked),
      .overlong_checked (overlong_checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver decides afresh on every edge whether it takes a result beat.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= take_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // A hung handshake ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Payloads lean toward all zeros and all ones so that the sign bits and the bits that
   // fall off the top of a long are hit often.
   function automatic logic [6:0] pick_payload();
      int roll;
      roll = $urandom_range(9);
      if (roll < 2) return 7'h00;
      if (roll < 4) return 7'h7F;
      return 7'($urandom_range(127));
   endfunction

   // Offers one beat and returns at the edge that accepts it. Valid is lowered only when an
   // idle gap is chosen, so a beat that follows at once keeps valid high without a glitch.
   task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, data_byte: data};
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // Sends one value of len bytes. A closed value clears the continuation bit on its last
   // byte; an open one keeps it set throughout, which makes it overlong at the kind's limit.
   // The kind field of the later bytes is random, since the block must ignore it there.
   task automatic send_value(input logic [1:0] kind, input int unsigned len, input bit closed);
      logic [7:0] data;
      logic [1:0] later_kind;
      for (int unsigned i = 0; i < len; i++) begin
         data[6:0] = pick_payload();
         data[7]   = (i != len - 1) || !closed;
         later_kind = 2'($urandom_range(KIND_RSVD));
         send_beat((i == 0) ? kind : later_kind, data);
      end
   endtask

   initial begin
      int          roll;
      int          target;
      logic [1:0]  kind;
      logic [1:0]  noise_kind;
      int unsigned budget;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, all without idling. Single-byte zero as an int, the reserved kind
      // code decoded as a long, a short that runs into its limit, a five-byte int whose
      // final byte makes it negative, an int that runs into its limit, and a ten-byte long
      // whose last payload carries bits beyond bit 63.
      send_beat(KIND_INT, 8'h00);
      send_beat(KIND_RSVD, 8'h7F);
      repeat (3) send_beat(KIND_SHORT, 8'hFF);
      repeat (4) send_beat(KIND_INT, 8'hFF);
      send_beat(KIND_INT, 8'h0F);
      repeat (5) send_beat(KIND_INT, 8'h80);
      repeat (9) send_beat(KIND_LONG, 8'hFF);
      send_beat(KIND_LONG, 8'h7F);

      // Random part. Most of it is well-formed values of random kind and length; some are
      // left open to run into the limit, and a few stray bytes break the framing.
      target = beats_sent + RANDOM_BEATS;
      while (beats_sent < target) begin
         case ((beats_sent / PHASE_BEATS) % 4)
            0: begin
               send_idle_pct = 0;
               take_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 60;
               take_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               take_stall_pct = 60;
            end
            default: begin
               send_idle_pct = 7;
               take_stall_pct = 7;
            end
         endcase
         kind = 2'($urandom_range(KIND_RSVD));
         case (kind)
            KIND_INT:   budget = 32'(LIMIT_INT);
            KIND_SHORT: budget = 32'(LIMIT_SHORT);
            default:    budget = 32'(LIMIT_LONG);
         endcase
         roll = $urandom_range(99);
         if (roll < 8) begin
            noise_kind = 2'($urandom_range(KIND_RSVD));
            send_beat(noise_kind, 8'($urandom_range(255)));
         end else if (roll < 18) begin
            send_value(kind, budget, 1'b0);
         end else begin
            send_value(kind, $urandom_range(budget, 1), 1'b1);
         end
      end
      req_valid <= 1'b0;

      // Let every predicted result come out, then give the block time to show any extra one.
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d byte beats of all four kind codes under four idle/stall mixes.",
               beats_sent);
      $display("Checked %0d decoded values and %0d overlong encodings.",
               values_checked, overlong_checked);
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
